>>> rtl/core/pwm_dimmer_ramp_macros.svh
// assertion macros for the pwm dimmer ramp
`ifndef PWM_DIMMER_RAMP_MACROS_SVH
`define PWM_DIMMER_RAMP_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define PDR_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pdr assertion failed");

// consequent must hold in the cycle after the antecedent
`define PDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pdr assertion failed");

`else

`define PDR_ASSERT(label, ante, cons)
`define PDR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/pdr_pkg.sv
// shared types and constants for the pwm dimmer ramp
package pdr_pkg;

  localparam int LevelW       = 17;
  localparam int StepW        = 18;
  localparam int TickW        = 27;
  localparam int PctW         = 8;
  localparam int MsW          = 16;
  localparam int ScaleW       = 17;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 17;

  // number of equal steps in one ramp, a power of two
  localparam int StepsPerRamp = 64;
  localparam int StepsW       = $clog2(StepsPerRamp + 1);

  localparam logic [LevelW-1:0] OneQ16     = LevelW'(65536);
  localparam logic [6:0]        PctMax     = 7'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOnIsHigh = 1'b0,
    CfgScale    = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OpSetLevel = 1'b0,
    OpTick     = 1'b1
  } op_e;

endpackage

>>> rtl/core/pdr_if.sv
// handshake channels of the pwm dimmer ramp

interface pdr_cfg_if;
  import pdr_pkg::*;
  logic                valid;
  logic                ready;
  cfg_idx_e            idx;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

interface pdr_in_if;
  import pdr_pkg::*;
  logic            valid;
  logic            ready;
  op_e             op;
  logic [PctW-1:0] intensity;
  logic [MsW-1:0]  ramp_ms;
  modport source (output valid, output op, output intensity, output ramp_ms, input ready);
  modport sink   (input valid, input op, input intensity, input ramp_ms, output ready);
endinterface

interface pdr_out_if;
  import pdr_pkg::*;
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] duty;
  logic              ramping;
  logic              duty_changed;
  modport source (output valid, output duty, output ramping, output duty_changed,
                  input ready);
  modport sink   (input valid, input duty, input ramping, input duty_changed,
                  output ready);
endinterface

>>> rtl/core/pwm_dimmer_ramp.sv
// pwm dimmer ramp: percent intensity to q16 duty with an optional linear ramp
`include "pwm_dimmer_ramp_macros.svh"

// the block turns a 0..100 percent intensity into a q16 pwm duty (65536 is full on)
// and moves the duty there at once or along a linear ramp of 64 equal steps driven
// by microsecond tick items. a set item (op 0) is walked by the sequencer through
// fraction, scale multiply and state update, using one 17x17 multiplier for the
// scale; a tick item (op 1) goes straight to the state update. one item is worked
// on at a time and in_i.ready is high only while the sequencer is idle. every
// item yields exactly one result item; a registered output slot holds it, so the
// next item is taken while the result still waits, and the sequencer only stalls
// if a second result is ready before the first is taken. configuration writes
// (polarity, scale) are always accepted and should be made while no item is in
// flight. a ramped set does not touch the duty (duty_changed 0); each step updates
// it and the last step lands exactly on target.
module pwm_dimmer_ramp (
  input  logic      clk_i,
  input  logic      rst_ni,
  pdr_cfg_if.sink   cfg_i,
  pdr_in_if.sink    in_i,
  pdr_out_if.source out_o
);
  import pdr_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StFrac,
    StScale,
    StSet,
    StTick,
    StEmit
  } state_e;

  state_e state_q;

  // configuration
  logic              on_is_high_q;
  logic [ScaleW-1:0] scale_q;

  // latched item
  logic [6:0]        pct_q;     // already clamped to 100
  logic [MsW-1:0]    ms_q;

  // datapath
  logic [LevelW-1:0] frac_q;
  logic [LevelW-1:0] cur_q;
  logic [LevelW-1:0] target_q;
  logic signed [StepW-1:0] step_q;
  logic [StepsW-1:0] steps_left_q;
  logic [TickW-1:0]  tick_cnt_q;
  logic [TickW-1:0]  interval_q;
  logic              ramp_q;
  logic              changed_q;

  // output slot
  logic              out_valid_q;
  logic [LevelW-1:0] out_duty_q;
  logic              out_ramping_q;
  logic              out_changed_q;

  // intensity fraction: (pct * 65536 + 50) / 100 as pct * 655 plus a small
  // reciprocal multiply for the remainder part (pct * 36 + 50) / 100
  logic [LevelW-1:0] frac_whole;
  logic [11:0]       frac_rem;
  logic [24:0]       frac_rem_prod;
  logic [LevelW-1:0] frac_c;

  assign frac_whole    = LevelW'(pct_q) * LevelW'(655);
  assign frac_rem      = 12'(pct_q) * 12'd36 + 12'd50;
  assign frac_rem_prod = 25'(frac_rem) * 25'd5243;
  assign frac_c        = frac_whole + LevelW'(frac_rem_prod >> 19);

  // scale multiplier: scale times fraction, rounded to nearest and saturated
  logic [33:0]       mul_p;
  logic [34:0]       mul_rnd;
  logic [18:0]       scaled;
  logic [LevelW-1:0] target_c;

  assign mul_p    = 34'(scale_q) * 34'(frac_q);
  assign mul_rnd  = 35'(mul_p) + 35'd32768;
  assign scaled   = mul_rnd[34:16];
  assign target_c = (scaled > 19'(OneQ16)) ? OneQ16 : scaled[LevelW-1:0];

  // ramp setup
  logic signed [StepW-1:0] diff_s;
  logic signed [StepW-1:0] step_c;
  logic [25:0]             ms_us;
  logic [TickW-1:0]        interval_raw;
  logic [TickW-1:0]        interval_c;

  assign diff_s       = $signed({1'b0, target_q}) - $signed({1'b0, cur_q});
  assign step_c       = StepW'(diff_s / StepsPerRamp);   // truncates toward zero
  assign ms_us        = 26'(ms_q) * 26'd1000;
  assign interval_raw = TickW'(ms_us / StepsPerRamp);
  assign interval_c   = (interval_raw == '0) ? TickW'(1) : interval_raw;

  // ramp step
  logic [TickW-1:0]   tick_inc;
  logic [StepsW-1:0]  steps_dec;
  logic signed [18:0] next_s;
  logic [LevelW-1:0]  next_sat;

  assign tick_inc  = tick_cnt_q + TickW'(1);
  assign steps_dec = (steps_left_q != '0) ? steps_left_q - StepsW'(1) : steps_left_q;
  assign next_s    = $signed({2'b00, cur_q}) + 19'(step_q);
  always_comb begin
    if (next_s < 0) begin
      next_sat = '0;
    end else if (next_s > $signed(19'(OneQ16))) begin
      next_sat = OneQ16;
    end else begin
      next_sat = next_s[LevelW-1:0];
    end
  end

  assign cfg_i.ready        = 1'b1;
  assign in_i.ready         = (state_q == StIdle);
  assign out_o.valid        = out_valid_q;
  assign out_o.duty         = out_duty_q;
  assign out_o.ramping      = out_ramping_q;
  assign out_o.duty_changed = out_changed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      on_is_high_q  <= 1'b1;
      scale_q       <= ScaleW'(65536);
      pct_q         <= '0;
      ms_q          <= '0;
      frac_q        <= '0;
      cur_q         <= '0;
      target_q      <= '0;
      step_q        <= '0;
      steps_left_q  <= '0;
      tick_cnt_q    <= '0;
      interval_q    <= '0;
      ramp_q        <= 1'b0;
      changed_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_duty_q    <= '0;
      out_ramping_q <= 1'b0;
      out_changed_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.idx)
          CfgOnIsHigh: on_is_high_q <= cfg_i.data[0];
          CfgScale:    scale_q      <= cfg_i.data;
          default:     ;
        endcase
      end

      // result taken drains the output slot, unless a new result refills it
      if (out_valid_q && out_o.ready && (state_q != StEmit)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            pct_q   <= (in_i.intensity > PctW'(PctMax)) ? PctMax : in_i.intensity[6:0];
            ms_q    <= in_i.ramp_ms;
            state_q <= (in_i.op == OpTick) ? StTick : StFrac;
          end
        end
        StFrac: begin
          frac_q  <= on_is_high_q ? frac_c : OneQ16 - frac_c;
          state_q <= StScale;
        end
        StScale: begin
          target_q <= target_c;
          state_q  <= StSet;
        end
        StSet: begin
          if (ms_q == '0) begin
            // immediate jump to target
            cur_q        <= target_q;
            ramp_q       <= 1'b0;
            steps_left_q <= '0;
            tick_cnt_q   <= '0;
            step_q       <= '0;
            changed_q    <= 1'b1;
          end else begin
            step_q       <= step_c;
            steps_left_q <= StepsW'(StepsPerRamp);
            interval_q   <= interval_c;
            tick_cnt_q   <= '0;
            ramp_q       <= 1'b1;
            changed_q    <= 1'b0;
          end
          state_q <= StEmit;
        end
        StTick: begin
          changed_q <= 1'b0;
          if (ramp_q) begin
            if (tick_inc >= interval_q) begin
              tick_cnt_q   <= '0;
              steps_left_q <= steps_dec;
              changed_q    <= 1'b1;
              if (steps_dec == '0) begin
                // last step lands exactly on target
                cur_q  <= target_q;
                ramp_q <= 1'b0;
              end else begin
                cur_q <= next_sat;
              end
            end else begin
              tick_cnt_q <= tick_inc;
            end
          end
          state_q <= StEmit;
        end
        StEmit: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q   <= 1'b1;
            out_duty_q    <= cur_q;
            out_ramping_q <= ramp_q;
            out_changed_q <= changed_q;
            state_q       <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // duty never leaves the q16 range
  `PDR_ASSERT(a_duty_range, 1'b1, cur_q <= OneQ16)
  // an active ramp always has a step left to take
  `PDR_ASSERT(a_ramp_steps, ramp_q, steps_left_q != '0)
  // tick counter stays below its interval while ramping
  `PDR_ASSERT(a_tick_bound, ramp_q, tick_cnt_q < interval_q)
  // an accepted item keeps the input closed in the next cycle
  `PDR_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)

endmodule
